[rtl/coap_option_stream_parser_assert.svh]
// Assertion macros for the parser RTL.
`ifndef COAP_OPTION_STREAM_PARSER_ASSERT_SVH
`define COAP_OPTION_STREAM_PARSER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define COSP_ASSERT_IMPLY(label, clk, rstn, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |-> (expr)) \
        else $error("cosp assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define COSP_ASSERT_NEXT(label, clk, rstn, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (expr)) \
        else $error("cosp assertion failed");

`endif

[rtl/cosp_pkg.sv]
`default_nettype none

package cosp_pkg;

    localparam int MAX_OPTIONS = 16;
    localparam int OPT_CNT_W = $clog2(MAX_OPTIONS + 1);
    localparam logic [OPT_CNT_W-1:0] OPT_LIMIT = OPT_CNT_W'(MAX_OPTIONS);

    localparam logic [7:0]  PAYLOAD_MARKER = 8'hFF;
    localparam logic [3:0]  NIB_EXT1       = 4'd13;
    localparam logic [3:0]  NIB_EXT2       = 4'd14;
    localparam logic [3:0]  NIB_RESERVED   = 4'd15;
    localparam logic [16:0] EXT1_BIAS      = 17'd13;
    localparam logic [16:0] EXT2_BIAS      = 17'd269;
    localparam logic [15:0] OFFSET_MAX     = 16'hFFFF;

    typedef enum logic [2:0] {
        KIND_OPTION  = 3'd0,
        KIND_PAYLOAD = 3'd1,
        KIND_CODE    = 3'd2,
        KIND_END     = 3'd3,
        KIND_ERROR   = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NO_PAYLOAD = 3'd0,
        ERR_RSV_DELTA  = 3'd1,
        ERR_RSV_LENGTH = 3'd2,
        ERR_TRUNCATED  = 3'd3,
        ERR_OVERFLOW   = 3'd4,
        ERR_TOO_MANY   = 3'd5
    } err_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        kind_t       result_kind;
        logic [3:0]  option_index;
        logic [15:0] abs_number;
        logic [16:0] option_delta;
        logic [16:0] option_length;
        logic [15:0] value_offset;
        logic [15:0] payload_offset;
        logic [15:0] payload_length;
        logic [4:0]  option_count;
        logic [7:0]  code_value;
        err_t        error_code;
        logic        last_of_run;
    } out_item_t;

    // Results caused by one item, in order.
    typedef struct packed {
        logic [1:0] count;
        out_item_t  first;
        out_item_t  second;
    } run_t;

    function automatic out_item_t mk_result(kind_t kind);
        out_item_t r;
        r = '0;
        r.result_kind = kind;
        return r;
    endfunction

    function automatic out_item_t mk_error(err_t code);
        out_item_t r;
        r = mk_result(KIND_ERROR);
        r.error_code = code;
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/cosp_core.sv]
`default_nettype none

module cosp_core (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             code_prefix_enable,
    input  wire cosp_pkg::in_item_t item,
    input  wire logic             advance,
    output cosp_pkg::run_t        run
);

    typedef enum logic [10:0] {
        PH_HDR  = 11'b000_0000_0001,
        PH_CODE = 11'b000_0000_0010,
        PH_DX1  = 11'b000_0000_0100,
        PH_DX2A = 11'b000_0000_1000,
        PH_DX2B = 11'b000_0001_0000,
        PH_LX1  = 11'b000_0010_0000,
        PH_LX2A = 11'b000_0100_0000,
        PH_LX2B = 11'b000_1000_0000,
        PH_VAL  = 11'b001_0000_0000,
        PH_PAY  = 11'b010_0000_0000,
        PH_IDLE = 11'b100_0000_0000
    } phase_t;

    phase_t                         phase_reg, phase_next;
    logic [15:0]                    number_reg, number_next;
    logic [16:0]                    delta_reg, delta_next;
    logic [16:0]                    length_reg, length_next;
    logic [7:0]                     ext_hi_reg, ext_hi_next;
    logic [16:0]                    remain_reg, remain_next;
    logic [15:0]                    offset_reg, offset_next;
    logic [cosp_pkg::OPT_CNT_W-1:0] seen_reg, seen_next;
    logic [15:0]                    pay_start_reg, pay_start_next;
    logic                           has_pay_reg, has_pay_next;

    logic [3:0]           dnib, lnib;
    logic                 do_after, do_finish;
    logic [17:0]          num_sum;
    logic [31:0]          seen_wide;
    cosp_pkg::out_item_t  sw_res, tail_res;
    logic                 sw_v, tail_v;
    logic [15:0]          cur_offset;

    assign dnib = item.data_byte[7:4];
    assign lnib = item.data_byte[3:0];

    always_comb begin
        phase_next     = phase_reg;
        number_next    = number_reg;
        delta_next     = delta_reg;
        length_next    = length_reg;
        ext_hi_next    = ext_hi_reg;
        remain_next    = remain_reg;
        offset_next    = offset_reg;
        seen_next      = seen_reg;
        pay_start_next = pay_start_reg;
        has_pay_next   = has_pay_reg;
        do_after       = 1'b0;
        do_finish      = 1'b0;
        sw_res         = '0;
        sw_v           = 1'b0;
        tail_res       = '0;
        tail_v         = 1'b0;
        num_sum        = '0;
        seen_wide      = '0;

        if (item.first_byte) begin
            phase_next     = code_prefix_enable ? PH_CODE : PH_HDR;
            number_next    = '0;
            delta_next     = '0;
            length_next    = '0;
            ext_hi_next    = '0;
            remain_next    = '0;
            offset_next    = '0;
            seen_next      = '0;
            pay_start_next = '0;
            has_pay_next   = 1'b0;
        end
        cur_offset = offset_next;

        unique case (phase_next)
            PH_IDLE: begin
            end
            PH_CODE: begin
                sw_res = cosp_pkg::mk_result(cosp_pkg::KIND_CODE);
                sw_res.code_value = item.data_byte;
                sw_v = 1'b1;
                phase_next = PH_HDR;
            end
            PH_HDR: begin
                if (item.data_byte == cosp_pkg::PAYLOAD_MARKER) begin
                    sw_v = 1'b1;
                    if (item.last_byte) begin
                        sw_res = cosp_pkg::mk_error(cosp_pkg::ERR_NO_PAYLOAD);
                        phase_next = PH_IDLE;
                    end else begin
                        pay_start_next = (cur_offset != cosp_pkg::OFFSET_MAX) ?
                                         cur_offset + 16'd1 : cur_offset;
                        has_pay_next = 1'b1;
                        sw_res = cosp_pkg::mk_result(cosp_pkg::KIND_PAYLOAD);
                        sw_res.payload_offset = pay_start_next;
                        phase_next = PH_PAY;
                    end
                end else if (dnib == cosp_pkg::NIB_RESERVED) begin
                    sw_res = cosp_pkg::mk_error(cosp_pkg::ERR_RSV_DELTA);
                    sw_v = 1'b1;
                    phase_next = PH_IDLE;
                end else if (lnib == cosp_pkg::NIB_RESERVED) begin
                    sw_res = cosp_pkg::mk_error(cosp_pkg::ERR_RSV_LENGTH);
                    sw_v = 1'b1;
                    phase_next = PH_IDLE;
                end else if (seen_next >= cosp_pkg::OPT_LIMIT) begin
                    sw_res = cosp_pkg::mk_error(cosp_pkg::ERR_TOO_MANY);
                    sw_v = 1'b1;
                    phase_next = PH_IDLE;
                end else begin
                    delta_next  = 17'(dnib);
                    length_next = 17'(lnib);
                    if (dnib == cosp_pkg::NIB_EXT1) begin
                        phase_next = PH_DX1;
                    end else if (dnib == cosp_pkg::NIB_EXT2) begin
                        phase_next = PH_DX2A;
                    end else begin
                        do_after = 1'b1;
                    end
                end
            end
            PH_DX1: begin
                delta_next = 17'(item.data_byte) + cosp_pkg::EXT1_BIAS;
                do_after = 1'b1;
            end
            PH_DX2A: begin
                ext_hi_next = item.data_byte;
                phase_next = PH_DX2B;
            end
            PH_DX2B: begin
                delta_next = 17'({ext_hi_next, item.data_byte}) + cosp_pkg::EXT2_BIAS;
                do_after = 1'b1;
            end
            PH_LX1: begin
                length_next = 17'(item.data_byte) + cosp_pkg::EXT1_BIAS;
                do_finish = 1'b1;
            end
            PH_LX2A: begin
                ext_hi_next = item.data_byte;
                phase_next = PH_LX2B;
            end
            PH_LX2B: begin
                length_next = 17'({ext_hi_next, item.data_byte}) + cosp_pkg::EXT2_BIAS;
                do_finish = 1'b1;
            end
            PH_VAL: begin
                if (remain_next != '0) begin
                    remain_next = remain_next - 17'd1;
                end
                if (remain_next == '0) begin
                    phase_next = PH_HDR;
                end
            end
            PH_PAY: begin
            end
            default: begin
            end
        endcase

        // length extensions follow the delta extensions
        if (do_after) begin
            if (length_next == 17'(cosp_pkg::NIB_EXT1)) begin
                phase_next = PH_LX1;
            end else if (length_next == 17'(cosp_pkg::NIB_EXT2)) begin
                phase_next = PH_LX2A;
            end else begin
                do_finish = 1'b1;
            end
        end

        if (do_finish) begin
            num_sum = 18'(number_next) + 18'(delta_next);
            sw_v = 1'b1;
            if (num_sum[17:16] != 2'b00) begin
                sw_res = cosp_pkg::mk_error(cosp_pkg::ERR_OVERFLOW);
                phase_next = PH_IDLE;
            end else begin
                number_next = num_sum[15:0];
                seen_wide = 32'(seen_next);
                sw_res = cosp_pkg::mk_result(cosp_pkg::KIND_OPTION);
                sw_res.option_index  = seen_wide[3:0];
                sw_res.abs_number    = num_sum[15:0];
                sw_res.option_delta  = delta_next;
                sw_res.option_length = length_next;
                sw_res.value_offset  = (length_next != '0) ? cur_offset + 16'd1 : '0;
                seen_next   = seen_next + cosp_pkg::OPT_CNT_W'(1);
                remain_next = length_next;
                phase_next  = (length_next != '0) ? PH_VAL : PH_HDR;
            end
        end

        if (item.last_byte && phase_next != PH_IDLE) begin
            tail_v = 1'b1;
            if (phase_next == PH_HDR || phase_next == PH_PAY) begin
                tail_res = cosp_pkg::mk_result(cosp_pkg::KIND_END);
                if (has_pay_next) begin
                    tail_res.payload_offset = pay_start_next;
                    tail_res.payload_length = cur_offset - pay_start_next + 16'd1;
                end
                seen_wide = 32'(seen_next);
                tail_res.option_count = seen_wide[4:0];
            end else begin
                tail_res = cosp_pkg::mk_error(cosp_pkg::ERR_TRUNCATED);
            end
            phase_next = PH_IDLE;
        end

        if (cur_offset != cosp_pkg::OFFSET_MAX) begin
            offset_next = cur_offset + 16'd1;
        end

        run = '0;
        if (sw_v && tail_v) begin
            run.count  = 2'd2;
            run.first  = sw_res;
            run.second = tail_res;
            run.second.last_of_run = 1'b1;
        end else if (sw_v || tail_v) begin
            run.count = 2'd1;
            run.first = sw_v ? sw_res : tail_res;
            run.first.last_of_run = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HDR;
            number_reg    <= '0;
            delta_reg     <= '0;
            length_reg    <= '0;
            ext_hi_reg    <= '0;
            remain_reg    <= '0;
            offset_reg    <= '0;
            seen_reg      <= '0;
            pay_start_reg <= '0;
            has_pay_reg   <= 1'b0;
        end else if (advance) begin
            phase_reg     <= phase_next;
            number_reg    <= number_next;
            delta_reg     <= delta_next;
            length_reg    <= length_next;
            ext_hi_reg    <= ext_hi_next;
            remain_reg    <= remain_next;
            offset_reg    <= offset_next;
            seen_reg      <= seen_next;
            pay_start_reg <= pay_start_next;
            has_pay_reg   <= has_pay_next;
        end
    end

endmodule

`default_nettype wire

[rtl/cosp_outq.sv]
`default_nettype none

// Two-entry result queue: takes up to two results at once, hands out one per cycle while m_ready is high.
module cosp_outq (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire cosp_pkg::run_t   run,
    output logic [1:0]            space,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output cosp_pkg::out_item_t   m_data
);

    cosp_pkg::out_item_t slot0_reg, slot0_next;
    cosp_pkg::out_item_t slot1_reg, slot1_next;
    logic [1:0]          cnt_reg, cnt_next;
    logic                pop;
    logic [1:0]          cnt_left;

    assign m_valid  = (cnt_reg != 2'd0);
    assign m_data   = slot0_reg;
    assign pop      = m_valid && m_ready;
    assign cnt_left = cnt_reg - {1'b0, pop};
    assign space    = 2'd2 - cnt_left;

    always_comb begin
        slot0_next = pop ? slot1_reg : slot0_reg;
        slot1_next = slot1_reg;
        cnt_next   = cnt_left;
        if (push) begin
            case (cnt_left)
                2'd0: begin
                    slot0_next = run.first;
                    slot1_next = run.second;
                end
                2'd1: begin
                    slot1_next = run.first;
                end
                default: begin
                end
            endcase
            cnt_next = cnt_left + run.count;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

`default_nettype wire

[rtl/coap_option_stream_parser.sv]
`default_nettype none

// Option-area byte parser. One byte per item on s_; results (option, payload
// start, code, end, error) leave on m_. A byte is registered at acceptance and
// parsed in the next cycle; its results enter a two-entry queue when the byte
// is committed, which waits until the queue has room for them. The input takes
// one byte per cycle while m_ready stays high and each byte causes at most one
// result. A byte causing two results (option then end or truncation error, or
// code then end) leaves an extra result in the queue, which drains one result
// per cycle while m_ready is high; the input stalls only when a byte finds too
// little room left in it. Config writes on cfg_ are always ready and should
// only be made while no item is in flight.
module coap_option_stream_parser (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic             cfg_data,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire cosp_pkg::in_item_t s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output cosp_pkg::out_item_t   m_data
);

    logic                code_en_reg;
    logic                in_valid_reg;
    cosp_pkg::in_item_t  in_item_reg;
    cosp_pkg::run_t      run;
    logic [1:0]          space;
    logic                commit;
    logic                run_one, run_two, pair_marked, in_stall;

    assign cfg_ready = 1'b1;
    assign commit    = in_valid_reg && (run.count <= space);
    assign s_ready   = !in_valid_reg || commit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            code_en_reg  <= 1'b0;
            in_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                code_en_reg <= cfg_data;
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
    end

    cosp_core u_core (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .code_prefix_enable (code_en_reg),
        .item               (in_item_reg),
        .advance            (commit),
        .run                (run)
    );

    cosp_outq u_outq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (commit),
        .run     (run),
        .space   (space),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    assign run_one     = in_valid_reg && (run.count == 2'd1);
    assign run_two     = in_valid_reg && (run.count == 2'd2);
    assign pair_marked = !run.first.last_of_run && run.second.last_of_run;
    assign in_stall    = in_valid_reg && !commit;

`include "coap_option_stream_parser_assert.svh"

    `COSP_ASSERT_IMPLY(a_single_is_last, aclk, aresetn, run_one, run.first.last_of_run)
    `COSP_ASSERT_IMPLY(a_pair_marks_second, aclk, aresetn, run_two, pair_marked)
    `COSP_ASSERT_NEXT(a_item_held, aclk, aresetn, in_stall, in_valid_reg && $stable(in_item_reg))
    `COSP_ASSERT_IMPLY(a_queue_bound, aclk, aresetn, 1'b1, space <= 2'd2)

endmodule

`default_nettype wire

[tb/cosp_option_check.sv]
module cosp_option_check (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic                cfg_data,
    input  logic                s_valid,
    input  logic                s_ready,
    input  cosp_pkg::in_item_t  s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  cosp_pkg::out_item_t m_data,
    output int                  mismatches,
    output int                  awaiting,
    output int                  bytes_in,
    output int                  results_out,
    output int                  error_reports
);
    import cosp_pkg::*;

    typedef enum logic [3:0] {
        ST_HEADER,
        ST_CODE,
        ST_DELTA_EXT1,
        ST_DELTA_EXT2_HI,
        ST_DELTA_EXT2_LO,
        ST_LEN_EXT1,
        ST_LEN_EXT2_HI,
        ST_LEN_EXT2_LO,
        ST_VALUE,
        ST_PAYLOAD,
        ST_IDLE
    } parse_state_t;

    // parser copy
    logic         prefix_on;
    parse_state_t phase;
    logic [15:0]  opt_number;
    logic [16:0]  hdr_delta;
    logic [16:0]  hdr_length;
    logic [7:0]   ext_hi;
    logic [16:0]  value_left;
    logic [15:0]  offset;
    logic [4:0]   opt_seen;
    logic [15:0]  pay_start;
    logic         pay_seen;

    out_item_t pending_results[$];
    int        run_count;

    int n_fail    = 0;
    int n_bytes   = 0;
    int n_results = 0;
    int n_errs    = 0;

    function automatic out_item_t fresh_result(kind_t k);
        out_item_t r;
        r = '0;
        r.result_kind = k;
        return r;
    endfunction

    task automatic emit(out_item_t r);
        pending_results.push_back(r);
        run_count++;
    endtask

    task automatic clear_block();
        phase      = ST_HEADER;
        opt_number = '0;
        hdr_delta  = '0;
        hdr_length = '0;
        ext_hi     = '0;
        value_left = '0;
        offset     = '0;
        opt_seen   = '0;
        pay_start  = '0;
        pay_seen   = 1'b0;
    endtask

    task automatic report_error(err_t e);
        out_item_t r;
        r = fresh_result(KIND_ERROR);
        r.error_code = e;
        emit(r);
        phase = ST_IDLE;
    endtask

    task automatic report_end();
        out_item_t r;
        r = fresh_result(KIND_END);
        if (pay_seen) begin
            r.payload_offset = pay_start;
            r.payload_length = offset - pay_start + 16'd1;
        end
        r.option_count = opt_seen;
        emit(r);
        phase = ST_IDLE;
    endtask

    task automatic close_header();
        logic [17:0] num;
        out_item_t   r;
        num = {2'b00, opt_number} + {1'b0, hdr_delta};
        if (num > 18'h0FFFF) begin
            report_error(ERR_OVERFLOW);
        end else begin
            opt_number      = num[15:0];
            r               = fresh_result(KIND_OPTION);
            r.option_index  = opt_seen[3:0];
            r.abs_number    = num[15:0];
            r.option_delta  = hdr_delta;
            r.option_length = hdr_length;
            r.value_offset  = (hdr_length != 0) ? offset + 16'd1 : 16'd0;
            emit(r);
            opt_seen   = opt_seen + 5'd1;
            value_left = hdr_length;
            phase      = (hdr_length != 0) ? ST_VALUE : ST_HEADER;
        end
    endtask

    task automatic delta_done();
        if (hdr_length == 17'(NIB_EXT1))
            phase = ST_LEN_EXT1;
        else if (hdr_length == 17'(NIB_EXT2))
            phase = ST_LEN_EXT2_HI;
        else
            close_header();
    endtask

    task automatic parse_byte(in_item_t it);
        logic [3:0] dn;
        logic [3:0] ln;
        out_item_t  r;
        run_count = 0;
        if (it.first_byte) begin
            clear_block();
            if (prefix_on)
                phase = ST_CODE;
        end
        // dead until the next block start
        if (phase == ST_IDLE)
            return;

        case (phase)
            ST_CODE: begin
                r = fresh_result(KIND_CODE);
                r.code_value = it.data_byte;
                emit(r);
                phase = ST_HEADER;
            end
            ST_HEADER: begin
                dn = it.data_byte[7:4];
                ln = it.data_byte[3:0];
                if (it.data_byte == PAYLOAD_MARKER) begin
                    if (it.last_byte) begin
                        report_error(ERR_NO_PAYLOAD);
                    end else begin
                        pay_start = (offset != OFFSET_MAX) ? offset + 16'd1 : OFFSET_MAX;
                        pay_seen  = 1'b1;
                        r = fresh_result(KIND_PAYLOAD);
                        r.payload_offset = pay_start;
                        emit(r);
                        phase = ST_PAYLOAD;
                    end
                end else if (dn == NIB_RESERVED) begin
                    report_error(ERR_RSV_DELTA);
                end else if (ln == NIB_RESERVED) begin
                    report_error(ERR_RSV_LENGTH);
                end else if (opt_seen >= MAX_OPTIONS) begin
                    report_error(ERR_TOO_MANY);
                end else begin
                    hdr_delta  = {13'd0, dn};
                    hdr_length = {13'd0, ln};
                    if (dn == NIB_EXT1)
                        phase = ST_DELTA_EXT1;
                    else if (dn == NIB_EXT2)
                        phase = ST_DELTA_EXT2_HI;
                    else
                        delta_done();
                end
            end
            ST_DELTA_EXT1: begin
                hdr_delta = {9'd0, it.data_byte} + EXT1_BIAS;
                delta_done();
            end
            ST_DELTA_EXT2_HI: begin
                ext_hi = it.data_byte;
                phase  = ST_DELTA_EXT2_LO;
            end
            ST_DELTA_EXT2_LO: begin
                hdr_delta = {1'b0, ext_hi, it.data_byte} + EXT2_BIAS;
                delta_done();
            end
            ST_LEN_EXT1: begin
                hdr_length = {9'd0, it.data_byte} + EXT1_BIAS;
                close_header();
            end
            ST_LEN_EXT2_HI: begin
                ext_hi = it.data_byte;
                phase  = ST_LEN_EXT2_LO;
            end
            ST_LEN_EXT2_LO: begin
                hdr_length = {1'b0, ext_hi, it.data_byte} + EXT2_BIAS;
                close_header();
            end
            ST_VALUE: begin
                if (value_left != 0)
                    value_left = value_left - 17'd1;
                if (value_left == 0)
                    phase = ST_HEADER;
            end
            default: begin
            end
        endcase

        if (it.last_byte && phase != ST_IDLE) begin
            if (phase == ST_HEADER || phase == ST_PAYLOAD)
                report_end();
            else
                report_error(ERR_TRUNCATED);
        end

        if (offset != OFFSET_MAX)
            offset = offset + 16'd1;

        if (run_count > 0) begin
            r = pending_results.pop_back();
            r.last_of_run = 1'b1;
            pending_results.push_back(r);
        end
    endtask

    function automatic int field_diff(string name, logic [16:0] want, logic [16:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    task automatic check_result(out_item_t got);
        out_item_t want;
        int        bad;
        n_results++;
        if (got.result_kind == KIND_ERROR)
            n_errs++;
        if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
            n_fail++;
        end else begin
            want = pending_results.pop_front();
            bad  = 0;
            bad += field_diff("result_kind", want.result_kind, got.result_kind);
            bad += field_diff("option_index", want.option_index, got.option_index);
            bad += field_diff("abs_number", want.abs_number, got.abs_number);
            bad += field_diff("option_delta", want.option_delta, got.option_delta);
            bad += field_diff("option_length", want.option_length, got.option_length);
            bad += field_diff("value_offset", want.value_offset, got.value_offset);
            bad += field_diff("payload_offset", want.payload_offset, got.payload_offset);
            bad += field_diff("payload_length", want.payload_length, got.payload_length);
            bad += field_diff("option_count", want.option_count, got.option_count);
            bad += field_diff("code_value", want.code_value, got.code_value);
            bad += field_diff("error_code", want.error_code, got.error_code);
            bad += field_diff("last_of_run", want.last_of_run, got.last_of_run);
            if (bad != 0)
                n_fail++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            prefix_on = 1'b0;
            clear_block();
            pending_results.delete();
        end else begin
            // results of an item never show up on the edge that accepts it
            if (m_valid && m_ready)
                check_result(m_data);
            if (cfg_valid && cfg_ready)
                prefix_on = cfg_data;
            if (s_valid && s_ready) begin
                n_bytes++;
                parse_byte(s_data);
            end
        end
        mismatches    <= n_fail;
        awaiting      <= pending_results.size();
        bytes_in      <= n_bytes;
        results_out   <= n_results;
        error_reports <= n_errs;
    end

endmodule

[tb/tb_coap_option_stream_parser.sv]
module tb_coap_option_stream_parser;
    import cosp_pkg::*;

    typedef in_item_t item_q_t[$];

    localparam int RAND_ITEMS   = 1300;
    localparam int PHASE_BLOCKS = 25;
    localparam int HOLD_AFTER   = 400;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 8;

    logic      aclk;
    logic      aresetn   = 1'b0;
    logic      cfg_valid = 1'b0;
    logic      cfg_data  = 1'b0;
    logic      s_valid   = 1'b0;
    in_item_t  s_data    = '0;
    logic      m_ready   = 1'b0;
    logic      cfg_ready;
    logic      s_ready;
    logic      m_valid;
    out_item_t m_data;

    int mismatches;
    int awaiting;
    int bytes_in;
    int results_out;
    int error_reports;

    int sent       = 0;
    int burst_left = 0;
    bit hold_done  = 1'b0;
    int rx_mode    = 0;
    int rx_left    = 0;

    coap_option_stream_parser dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    cosp_option_check option_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .mismatches    (mismatches),
        .awaiting      (awaiting),
        .bytes_in      (bytes_in),
        .results_out   (results_out),
        .error_reports (error_reports)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2400000;
        $display("Verification failed");
        $finish;
    end

    task automatic push_byte(input logic [7:0] d, input logic f, input logic l);
        in_item_t it;
        int       gap;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        it.data_byte  = d;
        it.first_byte = f;
        it.last_byte  = l;
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left--;
        sent++;
    endtask

    task automatic write_cfg(input logic v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // drain everything, then allow for bytes that cause no result
    task automatic settle();
        s_valid <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (awaiting != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic logic [3:0] nibble_of(int v);
        if (v < 13)
            return 4'(v);
        return (v < 269) ? NIB_EXT1 : NIB_EXT2;
    endfunction

    function automatic void push_ext(ref logic [7:0] raw[$], input int v);
        logic [15:0] w;
        if (v >= 269) begin
            w = 16'(v - 269);
            raw.push_back(w[15:8]);
            raw.push_back(w[7:0]);
        end else if (v >= 13) begin
            raw.push_back(8'(v - 13));
        end
    endfunction

    function automatic item_q_t make_block(bit prefix);
        logic [7:0] raw[$];
        item_q_t    blk;
        in_item_t   it;
        int         n_opt;
        int         dlt;
        int         len;
        int         pick;
        int         cut;
        bit         crowded;
        crowded = ($urandom_range(0, 99) < 8);
        n_opt   = crowded ? $urandom_range(14, 18) : $urandom_range(0, 5);
        if (prefix)
            raw.push_back(8'($urandom));
        repeat (n_opt) begin
            if (crowded) begin
                dlt = $urandom_range(0, 3);
                len = $urandom_range(0, 1);
            end else begin
                pick = $urandom_range(0, 9);
                if (pick < 6)      dlt = $urandom_range(0, 12);
                else if (pick < 8) dlt = $urandom_range(13, 268);
                else if (pick < 9) dlt = $urandom_range(269, 1500);
                else               dlt = $urandom_range(269, 65804);
                pick = $urandom_range(0, 39);
                if (pick < 28)      len = $urandom_range(0, 12);
                else if (pick < 39) len = $urandom_range(13, 30);
                else                len = $urandom_range(269, 271);
            end
            raw.push_back({nibble_of(dlt), nibble_of(len)});
            push_ext(raw, dlt);
            push_ext(raw, len);
            repeat (len) raw.push_back(8'($urandom));
        end
        if ($urandom_range(0, 1)) begin
            raw.push_back(PAYLOAD_MARKER);
            repeat ($urandom_range(1, 6)) raw.push_back(8'($urandom));
        end
        if (raw.size() == 0)
            raw.push_back(PAYLOAD_MARKER);

        // broken blocks: cut short, a reserved nibble, or no end mark at all
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            cut = $urandom_range(1, raw.size());
            while (raw.size() > cut) void'(raw.pop_back());
        end else if (pick < 15) begin
            cut = $urandom_range(0, raw.size() - 1);
            raw[cut] = $urandom_range(0, 1) ? {NIB_RESERVED, 4'($urandom)}
                                             : {4'($urandom), NIB_RESERVED};
        end
        foreach (raw[i]) begin
            it.data_byte  = raw[i];
            it.first_byte = (i == 0);
            it.last_byte  = (i == raw.size() - 1);
            blk.push_back(it);
        end
        if (pick >= 95) begin
            it = blk.pop_back();
            it.last_byte = 1'b0;
            blk.push_back(it);
        end
        return blk;
    endfunction

    // receiver: changing ready patterns, one long hold-off to back up the input
    initial begin
        forever begin
            @(posedge aclk);
            if (!hold_done && sent >= HOLD_AFTER) begin
                hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                if (rx_left <= 0) begin
                    rx_mode = $urandom_range(0, 3);
                    rx_left = $urandom_range(5, 60);
                end
                rx_left--;
                case (rx_mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom);
                    2:       m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= rx_left[2];
                endcase
            end
        end
    end

    initial begin
        item_q_t blk;
        bit      cfg_now;
        int      blocks_here;
        int      rand_sent;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        write_cfg(1'b0);

        // bytes before any block start parse as a fresh block
        push_byte(8'h10, 1'b0, 1'b0);
        push_byte(8'hD1, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b0);
        push_byte(8'hAB, 1'b0, 1'b0);
        // two-byte delta of maximum size: number overflow
        push_byte(8'hE2, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b0);
        push_byte(8'h33, 1'b0, 1'b0);
        // end mark inside a value
        push_byte(8'h0D, 1'b1, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'h55, 1'b0, 1'b1);
        // header completes on the end mark: option, then truncation
        push_byte(8'hEE, 1'b1, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'h01, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b1);
        push_byte(8'hF0, 1'b1, 1'b0);
        push_byte(8'h0F, 1'b1, 1'b0);
        push_byte(PAYLOAD_MARKER, 1'b1, 1'b1);
        push_byte(8'h00, 1'b1, 1'b0);
        push_byte(PAYLOAD_MARKER, 1'b0, 1'b0);
        push_byte(8'h12, 1'b0, 1'b0);
        push_byte(8'h34, 1'b0, 1'b1);
        push_byte(8'hD0, 1'b1, 1'b1);
        push_byte(8'h00, 1'b1, 1'b1);
        settle();

        write_cfg(1'b1);
        push_byte(8'h45, 1'b1, 1'b1);
        push_byte(8'h01, 1'b1, 1'b0);
        push_byte(PAYLOAD_MARKER, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b1);
        settle();

        cfg_now     = 1'b1;
        blocks_here = 0;
        rand_sent   = 0;
        while (rand_sent < RAND_ITEMS) begin
            if (blocks_here == PHASE_BLOCKS) begin
                settle();
                cfg_now = !cfg_now;
                write_cfg(cfg_now);
                blocks_here = 0;
            end
            if ($urandom_range(0, 19) == 0) begin
                repeat ($urandom_range(1, 4))
                    push_byte(8'($urandom), 1'($urandom), 1'($urandom));
            end
            blk = make_block(cfg_now);
            foreach (blk[i])
                push_byte(blk[i].data_byte, blk[i].first_byte, blk[i].last_byte);
            rand_sent += blk.size();
            blocks_here++;
        end
        settle();

        $display("Run covered %0d bytes and %0d checked results, %0d of them errors,",
                 bytes_in, results_out, error_reports);
        $display("with code prefix off and on and a long output stall that filled the block.");
        if (mismatches == 0 && awaiting == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/cosp_pkg.sv
rtl/cosp_core.sv
rtl/cosp_outq.sv
rtl/coap_option_stream_parser.sv
tb/cosp_option_check.sv
tb/tb_coap_option_stream_parser.sv
